@@ hw/rtl/awc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awc_pkg
// Shared types and constants for the AIMD congestion-window controller.
// ----------------------------------------------------------------------------
package awc_pkg;

   // default window format: unsigned Q20.16
   localparam int FRAC_BITS_DEF = 16;
   localparam int INT_BITS_DEF  = 20;

   localparam int TIME_W     = 32;
   localparam int LIMIT_W    = 16;
   localparam int COUNT_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RESET = LIMIT_W'(100);
   localparam logic [COUNT_W-1:0] COLLAPSE_RESET      = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] STREAK_MAX          = COUNT_W'(15);
   localparam int                 WINDOW_RESET_INT    = 25;
   localparam int                 THRESHOLD_RESET     = 1000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT_LIMIT  = 1'b0,
      CSR_COLLAPSE_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_GROW_CHECK,
      ST_DIVIDE,
      ST_ADD,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ hw/rtl/awc_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awc_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module awc_divider #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 36
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_W-1:0]       numerator,
   input  logic [DEN_W-1:0]       divisor,
   output awc_pkg::div_status_type status,
   output logic [NUM_W-1:0]       quotient
);
   import awc_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0] quo_ff,  quo_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = numerator;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so its top bit drops
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

@@ hw/rtl/aimd_window_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aimd_window_controller
// Slow-start / AIMD congestion window, updated once per acknowledgement.
// ----------------------------------------------------------------------------
// One acknowledgement is handled at a time. A timeout ack goes through EVAL
// and RESULT, a slow-start ack through EVAL, GROW_CHECK and RESULT; an ack in
// congestion avoidance (default Q20.16 window) goes through EVAL, DIVIDE, ADD
// and RESULT, DIVIDE waiting on the divider that forms 1.5/window one quotient
// bit per cycle. The input is ready again once the result is written to the
// output register, while that result may still wait for the consumer. The
// configuration port is always ready and must be written only while idle.
module aimd_window_controller #(
   parameter int FRAC_BITS = awc_pkg::FRAC_BITS_DEF,
   parameter int INT_BITS  = awc_pkg::INT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [awc_pkg::TIME_W-1:0]      req_send_time,
   input  logic [awc_pkg::TIME_W-1:0]      req_ack_time,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [INT_BITS-1:0]             rsp_window_datagrams,
   output logic                            rsp_was_timeout,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [awc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [awc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import awc_pkg::*;

   localparam int WIN_W = INT_BITS + FRAC_BITS;
   localparam int NUM_W = 2 * FRAC_BITS + 1;
   localparam int SUM_W = ((NUM_W > WIN_W) ? NUM_W : WIN_W) + 1;

   localparam logic [WIN_W-1:0] WIN_MAX   = {WIN_W{1'b1}};
   localparam logic [WIN_W-1:0] WIN_ONE   = WIN_W'(1) << FRAC_BITS;
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(WINDOW_RESET_INT) << FRAC_BITS;
   localparam logic [WIN_W:0]   WIN_TWO   = (WIN_W + 1)'(2) << FRAC_BITS;
   localparam logic [NUM_W-1:0] DIV_NUM   = NUM_W'(3) << (2 * FRAC_BITS - 1);
   localparam logic [INT_BITS-1:0] THR_RESET = INT_BITS'(THRESHOLD_RESET);

   state_type             state_ff,    state_in;
   logic [WIN_W-1:0]      window_ff,   window_in;
   logic [INT_BITS-1:0]   thr_ff,      thr_in;
   logic                  slow_ff,     slow_in;
   logic [COUNT_W-1:0]    streak_ff,   streak_in;
   logic [LIMIT_W-1:0]    limit_ff,    limit_in;
   logic [COUNT_W-1:0]    collapse_ff, collapse_in;
   logic [TIME_W-1:0]     rtt_ff,      rtt_in;
   logic                  timeout_ff,  timeout_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   logic [INT_BITS-1:0]   rsp_window_ff,  rsp_window_in;
   logic                  rsp_timeout_ff, rsp_timeout_in;

   logic [WIN_W+1:0]      triple_w;
   logic [WIN_W:0]        grow_sum;
   logic [SUM_W-1:0]      div_sum;
   logic [COUNT_W-1:0]    streak_next;
   logic [INT_BITS-1:0]   whole;
   logic [INT_BITS-1:0]   thr_three_q;
   logic [WIN_W-1:0]      win_three_q;
   logic                  timed_out;
   logic                  div_start;
   div_status_type        div_status;
   logic [NUM_W-1:0]      quotient;

   awc_divider #(
      .NUM_W (NUM_W),
      .DEN_W (WIN_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (DIV_NUM),
      .divisor   (window_ff),
      .status    (div_status),
      .quotient  (quotient)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      limit_in    = limit_ff;
      collapse_in = collapse_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TIMEOUT_LIMIT:  limit_in    = csr_data[LIMIT_W-1:0];
            CSR_COLLAPSE_COUNT: collapse_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // shared 3*window, used by the timeout and slow-start exit paths
   assign triple_w    = {2'b00, window_ff} + {1'b0, window_ff, 1'b0};
   assign thr_three_q = triple_w[WIN_W+1:FRAC_BITS+2];
   assign win_three_q = triple_w[WIN_W+1:2];
   assign grow_sum    = {1'b0, window_ff} + WIN_TWO;
   assign div_sum     = SUM_W'(window_ff) + SUM_W'(quotient);
   assign timed_out   = rtt_ff > TIME_W'(limit_ff);
   assign streak_next = (streak_ff == STREAK_MAX) ? streak_ff : streak_ff + COUNT_W'(1);
   assign whole       = window_ff[WIN_W-1:FRAC_BITS];

   always_comb begin
      state_in       = state_ff;
      window_in      = window_ff;
      thr_in         = thr_ff;
      slow_in        = slow_ff;
      streak_in      = streak_ff;
      rtt_in         = rtt_ff;
      timeout_in     = timeout_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_window_in  = rsp_window_ff;
      rsp_timeout_in = rsp_timeout_ff;
      div_start      = 1'b0;
      req_ready      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rtt_in   = req_ack_time - req_send_time;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            timeout_in = timed_out;
            if (timed_out) begin
               streak_in = streak_next;
               slow_in   = 1'b1;
               if (streak_next >= collapse_ff) begin
                  thr_in    = INT_BITS'(window_ff >> (FRAC_BITS + 1));
                  window_in = WIN_ONE;
               end else begin
                  thr_in    = thr_three_q;
                  window_in = WIN_W'({thr_three_q, {(FRAC_BITS - 1){1'b0}}});
               end
               state_in = ST_RESULT;
            end else begin
               streak_in = '0;
               if (slow_ff) begin
                  window_in = grow_sum[WIN_W] ? WIN_MAX : grow_sum[WIN_W-1:0];
                  state_in  = ST_GROW_CHECK;
               end else if (window_ff == '0) begin
                  window_in = WIN_MAX;
                  state_in  = ST_RESULT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_GROW_CHECK: begin
            // leave slow start once the window reaches the threshold
            if (window_ff >= {thr_ff, {FRAC_BITS{1'b0}}}) begin
               slow_in   = 1'b0;
               window_in = (win_three_q < WIN_ONE) ? WIN_ONE : win_three_q;
            end
            state_in = ST_RESULT;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            window_in = (div_sum > SUM_W'(WIN_MAX)) ? WIN_MAX : div_sum[WIN_W-1:0];
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_window_in  = (whole == '0) ? INT_BITS'(1) : whole;
               rsp_timeout_in = timeout_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WIN_RESET;
         thr_ff       <= THR_RESET;
         slow_ff      <= 1'b1;
         streak_ff    <= '0;
         limit_ff     <= TIMEOUT_LIMIT_RESET;
         collapse_ff  <= COLLAPSE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         thr_ff       <= thr_in;
         slow_ff      <= slow_in;
         streak_ff    <= streak_in;
         limit_ff     <= limit_in;
         collapse_ff  <= collapse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rtt_ff         <= rtt_in;
      timeout_ff     <= timeout_in;
      rsp_window_ff  <= rsp_window_in;
      rsp_timeout_ff <= rsp_timeout_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_window_datagrams = rsp_window_ff;
   assign rsp_was_timeout      = rsp_timeout_ff;

endmodule

@@ hw/rtl/awc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awc_checker
// Port-level checks for the AIMD window controller, bound to the top level.
// ----------------------------------------------------------------------------
module awc_checker #(
   parameter int INT_BITS = awc_pkg::INT_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [INT_BITS-1:0]             rsp_window_datagrams,
   input logic                            rsp_was_timeout
);
   import awc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_datagrams)
                                  && $stable(rsp_was_timeout))
      else $error("result changed while stalled");

   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_datagrams != '0)
      else $error("reported window below one");

   // one item at a time: input closes after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // a new result only shows up while an item is in flight
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without an item in flight");

endmodule

bind aimd_window_controller awc_checker #(.INT_BITS(INT_BITS)) u_awc_checker (.*);

@@ tb/sv/tb_aimd_window_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aimd_window_controller
// Self-checking bench for the AIMD congestion-window controller.
// ----------------------------------------------------------------------------
// Acknowledgements are sent with random gaps, and the response side stalls
// at random. An in-bench window model predicts the window and the timeout
// flag for every accepted acknowledgement. Each response is compared field
// by field with the oldest prediction. The run moves through several
// timeout-limit and collapse-count settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_aimd_window_controller;
   import awc_pkg::*;

   localparam int ITEMS_PER_PHASE = 210;
   localparam int NUM_PHASES      = 8;

   // Window model: tracks the controller state and queues predicted responses.
   class window_scoreboard;
      typedef logic [INT_BITS_DEF+FRAC_BITS_DEF-1:0] window_type;
      typedef logic [INT_BITS_DEF-1:0]               whole_type;
      typedef struct {
         whole_type window_datagrams;
         logic      was_timeout;
      } ack_outcome_type;

      logic [LIMIT_W-1:0] limit_ms;
      logic [COUNT_W-1:0] collapse_at;
      window_type         win;
      whole_type          threshold;
      logic               slow;
      logic [COUNT_W-1:0] streak;
      ack_outcome_type    outcomes[$];
      int unsigned        errors;
      int unsigned        results_seen;

      function new();
         limit_ms     = TIMEOUT_LIMIT_RESET;
         collapse_at  = COLLAPSE_RESET;
         win          = window_type'(WINDOW_RESET_INT) << FRAC_BITS_DEF;
         threshold    = whole_type'(THRESHOLD_RESET);
         slow         = 1'b1;
         streak       = '0;
         errors       = 0;
         results_seen = 0;
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("MISMATCH at result %0d: %s", results_seen, msg);
      endtask

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TIMEOUT_LIMIT:  limit_ms = data[LIMIT_W-1:0];
            CSR_COLLAPSE_COUNT: collapse_at = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Saturating window add.
      function window_type grow(window_type a, logic [63:0] b);
         logic [63:0] top;
         top = (64'd1 << (INT_BITS_DEF + FRAC_BITS_DEF)) - 64'd1;
         if (b > top - 64'(a)) return window_type'(top);
         return window_type'(64'(a) + b);
      endfunction

      function void note_ack(logic [TIME_W-1:0] send_t, logic [TIME_W-1:0] ack_t);
         logic [TIME_W-1:0] rtt;
         logic              timed_out;
         logic [63:0]       wide;
         window_type        one;
         whole_type         whole;
         ack_outcome_type   o;
         rtt       = ack_t - send_t;
         timed_out = rtt > TIME_W'(limit_ms);
         one       = window_type'(1) << FRAC_BITS_DEF;
         if (timed_out) begin
            if (streak != STREAK_MAX) streak++;
            if (streak >= collapse_at) begin
               threshold = whole_type'(win >> (FRAC_BITS_DEF + 1));
               win       = one;
            end else begin
               wide      = 64'(win) * 64'd3;
               threshold = whole_type'(wide >> (FRAC_BITS_DEF + 2));
               win       = window_type'(64'(threshold) << (FRAC_BITS_DEF - 1));
            end
            slow = 1'b1;
         end else begin
            streak = '0;
            if (slow) begin
               win = grow(win, 64'd2 << FRAC_BITS_DEF);
               if (64'(win) >= (64'(threshold) << FRAC_BITS_DEF)) begin
                  slow = 1'b0;
                  wide = (64'(win) * 64'd3) >> 2;
                  win  = window_type'(wide);
                  if (win < one) win = one;
               end
            end else if (win == '0) begin
               win = '1;
            end else begin
               win = grow(win, (64'd3 << (2 * FRAC_BITS_DEF - 1)) / 64'(win));
            end
         end
         whole = whole_type'(win >> FRAC_BITS_DEF);
         if (whole == '0) whole = whole_type'(1);
         o.window_datagrams = whole;
         o.was_timeout      = timed_out;
         outcomes.push_back(o);
      endfunction

      task check_result(whole_type window_datagrams, logic was_timeout);
         ack_outcome_type o;
         results_seen++;
         if (outcomes.size() == 0) begin
            report_mismatch("response with no acknowledgement outstanding");
            return;
         end
         o = outcomes.pop_front();
         if (window_datagrams !== o.window_datagrams)
            report_mismatch($sformatf("window_datagrams got %0d want %0d",
                                      window_datagrams, o.window_datagrams));
         if (was_timeout !== o.was_timeout)
            report_mismatch($sformatf("was_timeout got %b want %b",
                                      was_timeout, o.was_timeout));
      endtask

      function int pending();
         return outcomes.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [TIME_W-1:0]        req_send_time = '0;
   logic [TIME_W-1:0]        req_ack_time = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [INT_BITS_DEF-1:0]  rsp_window_datagrams;
   logic                     rsp_was_timeout;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   bit                       idle_on = 1'b1;
   int unsigned              stall_left = 0;
   window_scoreboard         sb = new();

   aimd_window_controller dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_send_time        (req_send_time),
      .req_ack_time         (req_ack_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_window_datagrams (rsp_window_datagrams),
      .rsp_was_timeout      (rsp_was_timeout),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Response side: stall in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 13) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_window_datagrams, rsp_was_timeout);
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Valid stays high after a transfer; only pause and drain lower it.
   task automatic send_ack(logic [TIME_W-1:0] send_t, logic [TIME_W-1:0] ack_t);
      req_valid     <= 1'b1;
      req_send_time <= send_t;
      req_ack_time  <= ack_t;
      do @(posedge clock); while (!req_ready);
      sb.note_ack(send_t, ack_t);
   endtask

   task automatic ack_after(logic [TIME_W-1:0] rtt);
      logic [TIME_W-1:0] s;
      s = $urandom;
      send_ack(s, s + rtt);
   endtask

   task automatic pause(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (idle_on && $urandom_range(0, 4) == 0) pause($urandom_range(1, 13));
   endtask

   // Hold off until every predicted response has been seen.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_settings(logic [LIMIT_W-1:0] limit, logic [COUNT_W-1:0] collapse);
      csr_valid <= 1'b1;
      csr_index <= CSR_TIMEOUT_LIMIT;
      csr_data  <= CSR_DATA_W'(limit);
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(CSR_TIMEOUT_LIMIT, CSR_DATA_W'(limit));
      csr_index <= CSR_COLLAPSE_COUNT;
      csr_data  <= CSR_DATA_W'(collapse);
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(CSR_COLLAPSE_COUNT, CSR_DATA_W'(collapse));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [LIMIT_W-1:0] limits[NUM_PHASES];
      logic [COUNT_W-1:0] collapses[NUM_PHASES];
      logic [TIME_W-1:0]  lim;
      logic [TIME_W-1:0]  s;
      int unsigned        burst_left;
      int unsigned        pick;

      limits    = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'($urandom), 16'd100, 16'd500,
                    16'($urandom)};
      collapses = '{4'd1, 4'd15, 4'd0, 4'd5, 4'($urandom), 4'd15, 4'd2, 4'($urandom)};
      burst_left = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: wrap-around times, limit edges, leaving slow start,
      // avoidance, collapse and a zero threshold.
      send_ack('0, '0);
      send_ack('1, 32'd99);
      send_ack('1, '1);
      send_ack('0, 32'd101);
      repeat (6) begin
         ack_after(1);
         maybe_pause();
      end
      repeat (3) ack_after($urandom_range(0, 100));
      send_ack('0, '1);
      send_ack('1, '0);
      repeat (6) begin
         ack_after(101 + $urandom_range(0, 50));
         maybe_pause();
      end
      repeat (3) ack_after($urandom_range(0, 100));
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         repeat (8) @(posedge clock);
         write_settings(limits[p], collapses[p]);
         idle_on = (p != 2) && (p != NUM_PHASES - 1);
         lim = TIME_W'(limits[p]);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            s    = $urandom;
            pick = $urandom_range(0, 99);
            if (burst_left != 0) begin
               burst_left--;
               ack_after(lim + 1 + $urandom_range(0, 5000));
            end else if (pick < 55) begin
               ack_after($urandom_range(0, lim));
            end else if (pick < 62) begin
               ack_after(lim);
            end else if (pick < 70) begin
               ack_after(lim + 1);
            end else if (pick < 85) begin
               burst_left = $urandom_range(1, 18);
               ack_after(lim + 1 + $urandom_range(0, 5000));
            end else if (pick < 95) begin
               ack_after($urandom);
            end else begin
               send_ack(s, $urandom);
            end
            maybe_pause();
            if (idle_on && $urandom_range(0, 199) == 0) drain();
         end
         drain();
      end

      repeat (60) @(posedge clock);
      if (sb.pending() != 0) sb.report_mismatch("predicted responses never arrived");
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
